### rtl/core/lmd_pkg.sv
package lmd_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int MAX_COLUMNS     = 1024;
    localparam int MAX_ROWS        = 1024;
    localparam int INDEX_WIDTH     = 10;
    localparam int COUNT_WIDTH     = 11;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int COL_ADDR_WIDTH  = $clog2(MAX_COLUMNS);
    localparam int NUM_BANKS       = 3;
    localparam int BANK_WIDTH      = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int NUM_FOUND       = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = CFG_INDEX_WIDTH'(1);

    // Bit positions of the three candidates an item can settle, in output order.
    localparam int FOUND_UPPER = 0;
    localparam int FOUND_LEFT  = 1;
    localparam int FOUND_END   = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [INDEX_WIDTH-1:0]         index_t;

    // One queue entry: everything the back end needs to emit the results of one item.
    typedef struct packed {
        logic [NUM_FOUND-1:0] found;
        index_t               row;
        index_t               column;
        sample_t              upper_value;
        sample_t              left_value;
        sample_t              end_value;
    } entry_t;

endpackage

### rtl/core/lmd_ram.sv
module lmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  write_en,
    input  logic [ADDR_WIDTH-1:0] write_addr,
    input  logic [WIDTH-1:0]      write_data,
    input  logic                  read_en,
    input  logic [ADDR_WIDTH-1:0] read_addr,
    output logic [WIDTH-1:0]      read_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] read_data_reg;

    always_ff @(posedge aclk) begin
        if (write_en) begin
            mem[write_addr] <= write_data;
        end
        if (read_en) begin
            read_data_reg <= mem[read_addr];
        end
    end

    assign read_data = read_data_reg;

endmodule

### rtl/core/lmd_front.sv
module lmd_front
    import lmd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  sample_t                    s_sample,
    input  logic                       queue_full,
    output logic                       push,
    output entry_t                     push_entry
);

    function automatic index_t last_index(input logic [COUNT_WIDTH-1:0] count,
                                          input logic [COUNT_WIDTH:0]   limit);
        logic [COUNT_WIDTH:0] wide;
        wide = {1'b0, count};
        if (count == '0) begin
            return '0;
        end else if (wide > limit) begin
            return INDEX_WIDTH'(limit - 1'b1);
        end else begin
            return INDEX_WIDTH'(wide - 1'b1);
        end
    endfunction

    function automatic logic [BANK_WIDTH-1:0] bank_inc(input logic [BANK_WIDTH-1:0] b);
        case (b)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [BANK_WIDTH-1:0] bank_dec(input logic [BANK_WIDTH-1:0] b);
        case (b)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    // Frame position and configuration.
    index_t                row_last_reg, col_last_reg;
    index_t                row_reg, row_next;
    index_t                col_reg, col_next;
    logic [BANK_WIDTH-1:0] bank_reg, bank_next;
    sample_t               prev1_reg, prev2_reg;

    // Classification stage, lined up with the registered line store reads.
    logic                  f1_valid_reg, f1_valid_next;
    sample_t               f1_sample_reg, f1_prev1_reg, f1_prev2_reg;
    index_t                f1_row_reg, f1_col_reg;
    logic [BANK_WIDTH-1:0] f1_up_bank_reg, f1_next_bank_reg;
    logic                  f1_bypass_reg, f1_col_end_reg, f1_row_end_reg;

    // Middle row window: columns j-1 and j of the row above the current one.
    sample_t               mid_left_reg, mid_center_reg;

    logic                      accept, f1_fire;
    logic                      col_at_end, row_at_end;
    logic [BANK_WIDTH-1:0]     up_bank, next_bank;
    logic [COL_ADDR_WIDTH-1:0] col_addr, next_addr;
    sample_t                   ram_rdata [NUM_BANKS];
    sample_t                   up_value, next_mid, next_ram;
    logic                      i_ge1, i_ge2, j_ge1, j_ge2;
    logic [NUM_FOUND-1:0]      found;

    assign s_ready    = !f1_valid_reg || !queue_full;
    assign accept     = s_valid && s_ready;
    assign f1_fire    = f1_valid_reg && !queue_full;
    assign col_at_end = (col_reg == col_last_reg);
    assign row_at_end = (row_reg == row_last_reg);

    // Rows rotate over three banks: the current row is written to bank_reg,
    // the row two above sits in the next bank and the row just above in the one before.
    assign up_bank   = bank_inc(bank_reg);
    assign next_bank = col_at_end ? bank_reg : bank_dec(bank_reg);
    assign col_addr  = COL_ADDR_WIDTH'(col_reg);
    assign next_addr = col_at_end ? '0 : COL_ADDR_WIDTH'(col_reg + 1'b1);

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        logic                      bank_write;
        logic [COL_ADDR_WIDTH-1:0] bank_raddr;

        assign bank_write = accept && (bank_reg == BANK_WIDTH'(k));
        assign bank_raddr = (up_bank == BANK_WIDTH'(k)) ? col_addr : next_addr;

        lmd_ram #(
            .WIDTH (SAMPLE_WIDTH),
            .DEPTH (MAX_COLUMNS)
        ) u_ram (
            .aclk       (aclk),
            .write_en   (bank_write),
            .write_addr (col_addr),
            .write_data (s_sample),
            .read_en    (accept),
            .read_addr  (bank_raddr),
            .read_data  (ram_rdata[k])
        );
    end

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        bank_next = bank_reg;
        if (col_at_end) begin
            col_next  = '0;
            row_next  = row_at_end ? '0 : index_t'(row_reg + 1'b1);
            bank_next = bank_inc(bank_reg);
        end else begin
            col_next = index_t'(col_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_last_reg <= '0;
            col_last_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            bank_reg     <= '0;
            prev1_reg    <= '0;
            prev2_reg    <= '0;
        end else if (cfg_write_en) begin
            case (cfg_index)
                REG_ROW_COUNT: begin
                    row_last_reg <= last_index(cfg_data, (COUNT_WIDTH+1)'(MAX_ROWS));
                end
                REG_COLUMN_COUNT: begin
                    col_last_reg <= last_index(cfg_data, (COUNT_WIDTH+1)'(MAX_COLUMNS));
                end
                default: begin
                end
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            bank_reg  <= bank_next;
            prev1_reg <= s_sample;
            prev2_reg <= prev1_reg;
        end
    end

    always_comb begin
        f1_valid_next = f1_valid_reg;
        if (accept) begin
            f1_valid_next = 1'b1;
        end else if (f1_fire) begin
            f1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_sample_reg    <= s_sample;
            f1_prev1_reg     <= prev1_reg;
            f1_prev2_reg     <= prev2_reg;
            f1_row_reg       <= row_reg;
            f1_col_reg       <= col_reg;
            f1_up_bank_reg   <= up_bank;
            f1_next_bank_reg <= next_bank;
            // With a single column the look-ahead read hits the entry being written.
            f1_bypass_reg    <= col_at_end && (col_reg == '0);
            f1_col_end_reg   <= col_at_end;
            f1_row_end_reg   <= row_at_end;
        end
    end

    always_comb begin
        case (f1_up_bank_reg)
            2'd0:    up_value = ram_rdata[0];
            2'd1:    up_value = ram_rdata[1];
            default: up_value = ram_rdata[2];
        endcase
        case (f1_next_bank_reg)
            2'd0:    next_ram = ram_rdata[0];
            2'd1:    next_ram = ram_rdata[1];
            default: next_ram = ram_rdata[2];
        endcase
        next_mid = f1_bypass_reg ? f1_sample_reg : next_ram;
    end

    assign i_ge1 = (f1_row_reg != '0);
    assign i_ge2 = (f1_row_reg > index_t'(1));
    assign j_ge1 = (f1_col_reg != '0);
    assign j_ge2 = (f1_col_reg > index_t'(1));

    always_comb begin
        found = '0;
        // Element one row up: the new sample is its lower neighbor.
        found[FOUND_UPPER] = i_ge1
            && (mid_center_reg > f1_sample_reg)
            && (!i_ge2 || (mid_center_reg > up_value))
            && (!j_ge1 || (mid_center_reg > mid_left_reg))
            && (f1_col_end_reg || (mid_center_reg > next_mid));
        // In the last row the previous sample now has its right neighbor.
        found[FOUND_LEFT] = f1_row_end_reg && j_ge1
            && (f1_prev1_reg > f1_sample_reg)
            && (!i_ge1 || (f1_prev1_reg > mid_left_reg))
            && (!j_ge2 || (f1_prev1_reg > f1_prev2_reg));
        // The final element of the frame has no lower or right neighbor.
        found[FOUND_END] = f1_row_end_reg && f1_col_end_reg
            && (!i_ge1 || (f1_sample_reg > mid_center_reg))
            && (!j_ge1 || (f1_sample_reg > f1_prev1_reg));
    end

    always_ff @(posedge aclk) begin
        if (f1_fire) begin
            if (!f1_col_end_reg) begin
                mid_left_reg <= mid_center_reg;
            end
            mid_center_reg <= next_mid;
        end
    end

    assign push                   = f1_fire && (found != '0);
    assign push_entry.found       = found;
    assign push_entry.row         = f1_row_reg;
    assign push_entry.column      = f1_col_reg;
    assign push_entry.upper_value = mid_center_reg;
    assign push_entry.left_value  = f1_prev1_reg;
    assign push_entry.end_value   = f1_sample_reg;

endmodule

### rtl/core/lmd_queue.sv
module lmd_queue
    import lmd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    entry_t                     mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_WIDTH:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/lmd_back.sv
module lmd_back
    import lmd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   head_valid,
    input  entry_t head_entry,
    output logic   pop,
    output logic   m_valid,
    input  logic   m_ready,
    output index_t m_row_index,
    output index_t m_column_index,
    output sample_t m_peak_value,
    output logic   m_last_of_run
);

    logic [NUM_FOUND-1:0] done_reg, done_next;
    logic [NUM_FOUND-1:0] remaining, pick, rest;
    logic                 load, last;
    logic                 m_valid_reg, m_valid_next;
    index_t               m_row_reg, m_col_reg, row_sel, col_sel;
    sample_t              m_value_reg, value_sel;
    logic                 m_last_reg;

    assign remaining = head_entry.found & ~done_reg;

    always_comb begin
        pick      = '0;
        row_sel   = head_entry.row;
        col_sel   = head_entry.column;
        value_sel = head_entry.end_value;
        if (remaining[FOUND_UPPER]) begin
            pick[FOUND_UPPER] = 1'b1;
            row_sel           = index_t'(head_entry.row - 1'b1);
            value_sel         = head_entry.upper_value;
        end else if (remaining[FOUND_LEFT]) begin
            pick[FOUND_LEFT] = 1'b1;
            col_sel          = index_t'(head_entry.column - 1'b1);
            value_sel        = head_entry.left_value;
        end else begin
            pick[FOUND_END] = 1'b1;
        end
    end

    assign rest = remaining & ~pick;
    assign last = (rest == '0);
    assign load = head_valid && (!m_valid_reg || m_ready);
    assign pop  = load && last;

    always_comb begin
        done_next    = done_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            done_next    = last ? '0 : (done_reg | pick);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_row_reg   <= row_sel;
            m_col_reg   <= col_sel;
            m_value_reg <= value_sel;
            m_last_reg  <= last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_index    = m_row_reg;
    assign m_column_index = m_col_reg;
    assign m_peak_value   = m_value_reg;
    assign m_last_of_run  = m_last_reg;

endmodule

### rtl/core/local_maximum_detector_core.sv
// Strict four-neighbor local maximum detector for a raster stream of signed samples.
// Write row_count (index 0) and column_count (index 1) through cfg_write_en, cfg_index
// and cfg_data while the block is idle; each write restarts the frame at element (0,0).
// Samples enter on the s_ channel in raster order, one item per clock while the queue
// has room. Each local maximum leaves on the m_ channel with its row, column and
// value; m_last_of_run marks the final result caused by one input item.
// Element (i-1,j) is decided when sample (i,j) arrives; in the last row the left
// neighbor of the new sample and, at frame end, the final element are decided too.
// An item passes the classification stage and the queue before its result reaches m_valid.
// Sustained rate is one item per cycle while the queue has room; an item in the last
// row that produces k results emits one result per cycle while m_ready is high.
// The line store is three banks of 1024 samples, one row each, each with one write
// and one registered read per cycle; a four-entry queue separates classification
// from result output, so input keeps flowing while m_ready is low until it fills.
// Reset clears position counters, both counts to one, the queue and the output valid.
module local_maximum_detector_core
    import lmd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COUNT_WIDTH-1:0]     cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [INDEX_WIDTH-1:0]     m_row_index,
    output logic [INDEX_WIDTH-1:0]     m_column_index,
    output logic signed [SAMPLE_WIDTH-1:0] m_peak_value,
    output logic                       m_last_of_run
);

    logic   push, queue_full, pop, head_valid;
    entry_t push_entry, head_entry;

    lmd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .queue_full   (queue_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    lmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    lmd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_index    (m_row_index),
        .m_column_index (m_column_index),
        .m_peak_value   (m_peak_value),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

### rtl/core/lmd_checker.sv
module lmd_checker
    import lmd_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [INDEX_WIDTH-1:0]  m_row_index,
    input logic [INDEX_WIDTH-1:0]  m_column_index,
    input logic [SAMPLE_WIDTH-1:0] m_peak_value,
    input logic                    m_last_of_run
);

    // A stalled result keeps its valid and its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_index)
            && $stable(m_column_index) && $stable(m_peak_value) && $stable(m_last_of_run))
        else $error("stalled result changed");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // After reset the input side is open at once.
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // The rest of an item's results follow without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("gap inside the results of one item");

endmodule

bind local_maximum_detector_core lmd_checker u_lmd_checker (.*);
